### hw/rtl/onewire_bus_master_assert.svh
// assertion macros for the onewire bus master rtl
// each macro expects clk and rst_n in scope
`ifndef ONEWIRE_BUS_MASTER_ASSERT_SVH
`define ONEWIRE_BUS_MASTER_ASSERT_SVH

// same-cycle implication
`define OWM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owm assertion failed");

// next-cycle implication
`define OWM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owm assertion failed");

`endif

### hw/rtl/owm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_pkg
// types, constants and helper functions of the 1-wire bus master
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int CFG_W       = 10;
    localparam int REG_COUNT   = 8;
    localparam int RECOVERY_US = 2;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [CFG_W-1:0] RESET_LOW_INIT  = 10'd500;
    localparam logic [CFG_W-1:0] WINDOW_INIT     = 10'd310;
    localparam logic [CFG_W-1:0] W1_LOW_INIT     = 10'd10;
    localparam logic [CFG_W-1:0] W1_HIGH_INIT    = 10'd50;
    localparam logic [CFG_W-1:0] W0_LOW_INIT     = 10'd60;
    localparam logic [CFG_W-1:0] RD_LOW_INIT     = 10'd2;
    localparam logic [CFG_W-1:0] RD_DELAY_INIT   = 10'd3;
    localparam logic [CFG_W-1:0] RD_TAIL_INIT    = 10'd60;

    typedef enum logic [3:0] {
        PH_IDLE          = 4'd0,
        PH_RST_LOW       = 4'd1,
        PH_RST_WAIT_HIGH = 4'd2,
        PH_RST_WINDOW    = 4'd3,
        PH_RST_FREE      = 4'd4,
        PH_RECOVER       = 4'd5,
        PH_WR_LOW        = 4'd6,
        PH_WR_HIGH       = 4'd7,
        PH_RD_LOW        = 4'd8,
        PH_RD_DELAY      = 4'd9,
        PH_RD_TAIL       = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_WRITE = 2'd1,
        OP_RBYTE = 2'd2,
        OP_RBIT  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_RESET = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_RBYTE = 3'd3,
        CMD_RBIT  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        REG_RESET_LOW = 3'd0,
        REG_WINDOW    = 3'd1,
        REG_W1_LOW    = 3'd2,
        REG_W1_HIGH   = 3'd3,
        REG_W0_LOW    = 3'd4,
        REG_RD_LOW    = 3'd5,
        REG_RD_DELAY  = 3'd6,
        REG_RD_TAIL   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_us;
        logic [CFG_W-1:0] presence_window_us;
        logic [CFG_W-1:0] write_one_low_us;
        logic [CFG_W-1:0] write_one_high_us;
        logic [CFG_W-1:0] write_zero_low_us;
        logic [CFG_W-1:0] read_low_us;
        logic [CFG_W-1:0] read_sample_delay_us;
        logic [CFG_W-1:0] read_tail_us;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] rx_data;
        logic       crc_zero;
        logic       rejected;
    } result_t;

    // a zero duration lasts one microsecond
    function automatic logic [CFG_W-1:0] span(input logic [CFG_W-1:0] v);
        return (v == '0) ? CFG_W'(1) : v;
    endfunction

    // dallas crc-8, reflected polynomial
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### hw/rtl/owm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_in_if / owm_out_if
// valid/ready channels carrying bus ticks and commands in, results out
// ----------------------------------------------------------------------------
interface owm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       line_level;

    modport source (output valid, output cmd, output tx_byte, output line_level,
                    input ready);
    modport sink   (input valid, input cmd, input tx_byte, input line_level,
                    output ready);
endinterface

interface owm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_data;
    logic       crc_zero;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output rx_data, output crc_zero, output rejected,
                    input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input rx_data, input crc_zero, input rejected,
                    output ready);
endinterface

### hw/rtl/owm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_cfg_regs
// slot timing registers, written through a plain write port
// ----------------------------------------------------------------------------
module owm_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [owm_pkg::CFG_W-1:0]  cfg_data,
    output owm_pkg::cfg_t              cfg
);

    owm_pkg::cfg_t cfg_reg;
    owm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (owm_pkg::reg_idx_t'(cfg_index))
                owm_pkg::REG_RESET_LOW: cfg_next.reset_low_us         = cfg_data;
                owm_pkg::REG_WINDOW:    cfg_next.presence_window_us   = cfg_data;
                owm_pkg::REG_W1_LOW:    cfg_next.write_one_low_us     = cfg_data;
                owm_pkg::REG_W1_HIGH:   cfg_next.write_one_high_us    = cfg_data;
                owm_pkg::REG_W0_LOW:    cfg_next.write_zero_low_us    = cfg_data;
                owm_pkg::REG_RD_LOW:    cfg_next.read_low_us          = cfg_data;
                owm_pkg::REG_RD_DELAY:  cfg_next.read_sample_delay_us = cfg_data;
                owm_pkg::REG_RD_TAIL:   cfg_next.read_tail_us         = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us         <= owm_pkg::RESET_LOW_INIT;
            cfg_reg.presence_window_us   <= owm_pkg::WINDOW_INIT;
            cfg_reg.write_one_low_us     <= owm_pkg::W1_LOW_INIT;
            cfg_reg.write_one_high_us    <= owm_pkg::W1_HIGH_INIT;
            cfg_reg.write_zero_low_us    <= owm_pkg::W0_LOW_INIT;
            cfg_reg.read_low_us          <= owm_pkg::RD_LOW_INIT;
            cfg_reg.read_sample_delay_us <= owm_pkg::RD_DELAY_INIT;
            cfg_reg.read_tail_us         <= owm_pkg::RD_TAIL_INIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/owm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_engine
// bus phase sequencer: one microsecond step per accepted item
// ----------------------------------------------------------------------------
`include "onewire_bus_master_assert.svh"

module owm_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [2:0]          cmd,
    input  logic [7:0]          tx_byte,
    input  logic                line_level,
    input  owm_pkg::cfg_t       cfg,
    output owm_pkg::result_t    res
);

    localparam int TW = owm_pkg::CFG_W;

    owm_pkg::phase_t  phase_reg, phase_next, phase_s;
    owm_pkg::op_t     op_kind_reg, op_kind_next, op_s;
    logic [TW-1:0]    us_timer_reg, us_timer_next, us_s;
    logic [TW-1:0]    window_timer_reg, window_timer_next, wt_s;
    logic [3:0]       bit_index_reg, bit_index_next, bi_s;
    logic [7:0]       shift_reg, shift_next, sb_s;
    logic [7:0]       crc_reg, crc_next, crc_s;
    logic             presence_reg, presence_next, pres_s;

    logic             cmd_ok;
    logic             rejected_w;
    logic             done_w;
    logic [7:0]       rx_w;
    logic [TW:0]      us_inc;
    logic [TW-1:0]    wt_inc;
    logic [3:0]       bi_inc;
    logic             wbit;

    assign cmd_ok = (cmd == owm_pkg::CMD_RESET) || (cmd == owm_pkg::CMD_WRITE)
                 || (cmd == owm_pkg::CMD_RBYTE) || (cmd == owm_pkg::CMD_RBIT);

    // command start
    always_comb
    begin
        phase_s    = phase_reg;
        op_s       = op_kind_reg;
        us_s       = us_timer_reg;
        wt_s       = window_timer_reg;
        bi_s       = bit_index_reg;
        sb_s       = shift_reg;
        crc_s      = crc_reg;
        pres_s     = presence_reg;
        rejected_w = 1'b0;
        if (phase_reg == owm_pkg::PH_IDLE)
        begin
            if (cmd_ok)
            begin
                bi_s = '0;
                wt_s = '0;
                us_s = '0;
                case (cmd)
                    owm_pkg::CMD_RESET:
                    begin
                        op_s    = owm_pkg::OP_RESET;
                        pres_s  = 1'b0;
                        crc_s   = '0;
                        phase_s = owm_pkg::PH_RST_LOW;
                    end
                    owm_pkg::CMD_WRITE:
                    begin
                        op_s    = owm_pkg::OP_WRITE;
                        sb_s    = tx_byte;
                        phase_s = owm_pkg::PH_WR_LOW;
                    end
                    owm_pkg::CMD_RBYTE:
                    begin
                        op_s    = owm_pkg::OP_RBYTE;
                        sb_s    = '0;
                        phase_s = owm_pkg::PH_RD_LOW;
                    end
                    default:
                    begin
                        op_s    = owm_pkg::OP_RBIT;
                        sb_s    = '0;
                        phase_s = owm_pkg::PH_RD_LOW;
                    end
                endcase
            end
        end
        else if (cmd_ok)
        begin
            rejected_w = 1'b1;
        end
    end

    assign us_inc = {1'b0, us_s} + (TW+1)'(1);
    assign wt_inc = (wt_s != '1) ? wt_s + TW'(1) : wt_s;
    assign bi_inc = bi_s + 4'd1;
    assign wbit   = sb_s[bi_s[2:0]];

    // next state
    always_comb
    begin
        phase_next        = phase_s;
        op_kind_next      = op_s;
        us_timer_next     = us_s;
        window_timer_next = wt_s;
        bit_index_next    = bi_s;
        shift_next        = sb_s;
        crc_next          = crc_s;
        presence_next     = pres_s;
        done_w            = 1'b0;
        rx_w              = '0;
        case (phase_s)
            owm_pkg::PH_IDLE:
            begin
                phase_next = owm_pkg::PH_IDLE;
            end
            owm_pkg::PH_RST_LOW:
            begin
                us_timer_next = us_inc[TW-1:0];
                if (us_inc >= {1'b0, owm_pkg::span(cfg.reset_low_us)})
                begin
                    phase_next        = owm_pkg::PH_RST_WAIT_HIGH;
                    us_timer_next     = '0;
                    window_timer_next = '0;
                end
            end
            owm_pkg::PH_RST_WAIT_HIGH, owm_pkg::PH_RST_WINDOW, owm_pkg::PH_RST_FREE:
            begin
                if (phase_s == owm_pkg::PH_RST_FREE && line_level)
                begin
                    phase_next    = owm_pkg::PH_RECOVER;
                    us_timer_next = '0;
                end
                else
                begin
                    if (phase_s == owm_pkg::PH_RST_WAIT_HIGH && line_level)
                        phase_next = owm_pkg::PH_RST_WINDOW;
                    if (phase_s == owm_pkg::PH_RST_WINDOW && !line_level)
                    begin
                        presence_next = 1'b1;
                        phase_next    = owm_pkg::PH_RST_FREE;
                    end
                    window_timer_next = wt_inc;
                    if (wt_inc >= owm_pkg::span(cfg.presence_window_us))
                    begin
                        done_w        = 1'b1;
                        phase_next    = owm_pkg::PH_IDLE;
                        us_timer_next = '0;
                    end
                end
            end
            owm_pkg::PH_RECOVER:
            begin
                us_timer_next = us_inc[TW-1:0];
                if (us_inc >= (TW+1)'(owm_pkg::RECOVERY_US))
                begin
                    us_timer_next = '0;
                    if (op_s == owm_pkg::OP_RESET)
                    begin
                        done_w     = 1'b1;
                        phase_next = owm_pkg::PH_IDLE;
                    end
                    else
                    begin
                        bit_index_next = bi_inc;
                        if (op_s == owm_pkg::OP_RBIT || bi_inc >= 4'd8)
                        begin
                            if (op_s == owm_pkg::OP_RBYTE)
                            begin
                                rx_w     = sb_s;
                                crc_next = owm_pkg::crc_fold(crc_s, sb_s);
                            end
                            else if (op_s == owm_pkg::OP_RBIT)
                            begin
                                rx_w = {7'd0, sb_s[0]};
                            end
                            done_w     = 1'b1;
                            phase_next = owm_pkg::PH_IDLE;
                        end
                        else if (op_s == owm_pkg::OP_WRITE)
                        begin
                            phase_next = owm_pkg::PH_WR_LOW;
                        end
                        else
                        begin
                            phase_next = owm_pkg::PH_RD_LOW;
                        end
                    end
                end
            end
            owm_pkg::PH_WR_LOW:
            begin
                us_timer_next = us_inc[TW-1:0];
                if (us_inc >= {1'b0, owm_pkg::span(wbit ? cfg.write_one_low_us
                                                        : cfg.write_zero_low_us)})
                begin
                    us_timer_next = '0;
                    phase_next    = wbit ? owm_pkg::PH_WR_HIGH : owm_pkg::PH_RECOVER;
                end
            end
            owm_pkg::PH_WR_HIGH:
            begin
                us_timer_next = us_inc[TW-1:0];
                if (us_inc >= {1'b0, owm_pkg::span(cfg.write_one_high_us)})
                begin
                    us_timer_next = '0;
                    phase_next    = owm_pkg::PH_RECOVER;
                end
            end
            owm_pkg::PH_RD_LOW:
            begin
                us_timer_next = us_inc[TW-1:0];
                if (us_inc >= {1'b0, owm_pkg::span(cfg.read_low_us)})
                begin
                    us_timer_next = '0;
                    phase_next    = owm_pkg::PH_RD_DELAY;
                end
            end
            owm_pkg::PH_RD_DELAY:
            begin
                us_timer_next = us_inc[TW-1:0];
                if (us_inc >= {1'b0, owm_pkg::span(cfg.read_sample_delay_us)})
                begin
                    us_timer_next = '0;
                    phase_next    = owm_pkg::PH_RD_TAIL;
                end
            end
            owm_pkg::PH_RD_TAIL:
            begin
                // sample on the first microsecond of the tail
                if (us_s == '0)
                begin
                    if (op_s == owm_pkg::OP_RBYTE)
                        shift_next = {line_level, sb_s[7:1]};
                    else
                        shift_next = {7'd0, line_level};
                end
                us_timer_next = us_inc[TW-1:0];
                if (us_inc >= {1'b0, owm_pkg::span(cfg.read_tail_us)})
                begin
                    us_timer_next = '0;
                    phase_next    = owm_pkg::PH_RECOVER;
                end
            end
            default:
            begin
                phase_next    = owm_pkg::PH_IDLE;
                us_timer_next = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        res.drive_low = (phase_s == owm_pkg::PH_RST_LOW) || (phase_s == owm_pkg::PH_WR_LOW)
                     || (phase_s == owm_pkg::PH_RD_LOW);
        res.busy_res  = (phase_next != owm_pkg::PH_IDLE);
        res.done_res  = done_w;
        res.presence  = presence_next;
        res.rx_data   = rx_w;
        res.crc_zero  = (crc_next == '0);
        res.rejected  = rejected_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= owm_pkg::PH_IDLE;
            op_kind_reg      <= owm_pkg::OP_RESET;
            us_timer_reg     <= '0;
            window_timer_reg <= '0;
            bit_index_reg    <= '0;
            shift_reg        <= '0;
            crc_reg          <= '0;
            presence_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            op_kind_reg      <= op_kind_next;
            us_timer_reg     <= us_timer_next;
            window_timer_reg <= window_timer_next;
            bit_index_reg    <= bit_index_next;
            shift_reg        <= shift_next;
            crc_reg          <= crc_next;
            presence_reg     <= presence_next;
        end
    end

    `OWM_ASSERT_NEXT(a_done_goes_idle, accept && res.done_res, phase_reg == owm_pkg::PH_IDLE)
    `OWM_ASSERT_NEXT(a_drive_stays_busy, accept && res.drive_low, phase_reg != owm_pkg::PH_IDLE)
    `OWM_ASSERT_NEXT(a_reject_keeps_op, accept && res.rejected, $stable(op_kind_reg))
    `OWM_ASSERT_IMP(a_slot_index_range, phase_reg != owm_pkg::PH_IDLE, bit_index_reg < 4'd8)

endmodule

### hw/rtl/owm_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_out_stage
// result register between the sequencer and the result channel
// ----------------------------------------------------------------------------
module owm_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  owm_pkg::result_t   res,
    output logic               can_load,
    owm_out_if.source          out_ch
);

    logic             valid_reg, valid_next;
    owm_pkg::result_t data_reg;

    assign can_load = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ch.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign out_ch.valid     = valid_reg;
    assign out_ch.drive_low = data_reg.drive_low;
    assign out_ch.busy_res  = data_reg.busy_res;
    assign out_ch.done_res  = data_reg.done_res;
    assign out_ch.presence  = data_reg.presence;
    assign out_ch.rx_data   = data_reg.rx_data;
    assign out_ch.crc_zero  = data_reg.crc_zero;
    assign out_ch.rejected  = data_reg.rejected;

endmodule

### hw/rtl/onewire_bus_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_bus_master
// open-drain 1-wire bus master driven by one item per microsecond
//
// in_ch carries one transfer per microsecond: the sampled line level and an
// optional command (reset with presence, write byte, read byte, read bit).
// out_ch returns one result per input transfer: drive_low for that
// microsecond, busy/done flags, presence, read data, crc status and a
// rejected flag for commands sent while busy.
// slot timings come from eight 10-bit registers on the cfg write port; they are
// to be written while the bus is idle, which the block itself does not enforce.
// a result is registered and is valid in the cycle after its input transfer.
// throughput: one transfer per cycle while out_ch takes results; the phase
// timers, the crc fold and the result register update on an accepted transfer.
// when out_ch stalls, the result register holds and in_ch.ready drops until
// the result is taken; no transfer is lost or repeated.
// reset: timing registers return to their defaults, the sequencer goes idle,
// crc and presence clear, and the result register empties.
// ----------------------------------------------------------------------------
module onewire_bus_master (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [owm_pkg::CFG_W-1:0]  cfg_data,
    owm_in_if.sink                     in_ch,
    owm_out_if.source                  out_ch
);

    owm_pkg::cfg_t    cfg;
    owm_pkg::result_t res;
    logic             can_load;
    logic             accept;

    assign in_ch.ready = can_load;
    assign accept      = in_ch.valid && can_load;

    owm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (in_ch.cmd),
        .tx_byte    (in_ch.tx_byte),
        .line_level (in_ch.line_level),
        .cfg        (cfg),
        .res        (res)
    );

    owm_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .res      (res),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

### tb/tb_onewire_bus_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_onewire_bus_master
// self-checking testbench for the 1-wire bus master
//
// every microsecond transfer into in_ch is fed to a cycle-true model of the
// slot sequencer, which queues the result that out_ch must return for it.
// the bus line is played back from a few line behaviors (idle high, stuck
// low, a responding device, a presence pulse that never ends, random noise).
// a read bit runs with the default timings, directed commands run with
// all-zero timings, followed by random command streams under small random
// timings. both channels idle at random, and the receiver stalls long
// enough to back up the input channel.
// ----------------------------------------------------------------------------
module tb_onewire_bus_master;
    import owm_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_LIMIT  = 40;

    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    typedef enum {
        BUS_HIGH,
        BUS_STUCK_LOW,
        BUS_DEVICE,
        BUS_LATCH_LOW,
        BUS_NOISE
    } bus_mode_t;

    class bus_cycle_board;
        logic [CFG_W-1:0] timing [REG_COUNT];
        phase_t           phase;
        op_t              op;
        int               us_timer;
        int               window_timer;
        int               bit_index;
        logic [7:0]       shift_byte;
        logic [7:0]       crc;
        logic             presence_flag;
        result_t          owed[$];
        int               mismatches;

        function new();
            timing[REG_RESET_LOW] = RESET_LOW_INIT;
            timing[REG_WINDOW]    = WINDOW_INIT;
            timing[REG_W1_LOW]    = W1_LOW_INIT;
            timing[REG_W1_HIGH]   = W1_HIGH_INIT;
            timing[REG_W0_LOW]    = W0_LOW_INIT;
            timing[REG_RD_LOW]    = RD_LOW_INIT;
            timing[REG_RD_DELAY]  = RD_DELAY_INIT;
            timing[REG_RD_TAIL]   = RD_TAIL_INIT;
            phase         = PH_IDLE;
            op            = OP_RESET;
            us_timer      = 0;
            window_timer  = 0;
            bit_index     = 0;
            shift_byte    = 8'h00;
            crc           = 8'h00;
            presence_flag = 1'b0;
            mismatches    = 0;
        endfunction

        function int dur(reg_idx_t idx);
            int v;
            v = timing[idx];
            return (v == 0) ? 1 : v;
        endfunction

        function logic [7:0] dallas_crc(logic [7:0] acc, logic [7:0] data);
            logic [7:0] c;
            logic       lsb;
            c = acc ^ data;
            repeat (8)
            begin
                lsb = c[0];
                c   = {1'b0, c[7:1]};
                if (lsb)
                    c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void go(phase_t next);
            phase    = next;
            us_timer = 0;
        endfunction

        function void end_slot(inout result_t r);
            if (op == OP_RESET)
            begin
                r.done_res = 1'b1;
                go(PH_IDLE);
                return;
            end
            bit_index = (bit_index + 1) % 16;
            if (op == OP_RBIT || bit_index >= 8)
            begin
                if (op == OP_RBYTE)
                begin
                    r.rx_data = shift_byte;
                    crc       = dallas_crc(crc, shift_byte);
                end
                else if (op == OP_RBIT)
                    r.rx_data = {7'b0, shift_byte[0]};
                r.done_res = 1'b1;
                go(PH_IDLE);
            end
            else if (op == OP_WRITE)
                go(PH_WR_LOW);
            else
                go(PH_RD_LOW);
        endfunction

        // one microsecond of an active command
        function void advance(logic line, inout result_t r);
            logic b;
            case (phase)
                PH_RST_LOW:
                begin
                    r.drive_low = 1'b1;
                    us_timer++;
                    if (us_timer >= dur(REG_RESET_LOW))
                    begin
                        go(PH_RST_WAIT_HIGH);
                        window_timer = 0;
                    end
                end
                PH_RST_WAIT_HIGH, PH_RST_WINDOW, PH_RST_FREE:
                begin
                    if (phase == PH_RST_FREE && line)
                        go(PH_RECOVER);
                    else
                    begin
                        if (phase == PH_RST_WAIT_HIGH)
                        begin
                            if (line)
                                phase = PH_RST_WINDOW;
                        end
                        else if (phase == PH_RST_WINDOW && !line)
                        begin
                            presence_flag = 1'b1;
                            phase         = PH_RST_FREE;
                        end
                        if (window_timer < 1023)
                            window_timer++;
                        if (window_timer >= dur(REG_WINDOW))
                        begin
                            r.done_res = 1'b1;
                            go(PH_IDLE);
                        end
                    end
                end
                PH_RECOVER:
                begin
                    us_timer++;
                    if (us_timer >= RECOVERY_US)
                        end_slot(r);
                end
                PH_WR_LOW:
                begin
                    r.drive_low = 1'b1;
                    b = shift_byte[bit_index % 8];
                    us_timer++;
                    if (b && us_timer >= dur(REG_W1_LOW))
                        go(PH_WR_HIGH);
                    else if (!b && us_timer >= dur(REG_W0_LOW))
                        go(PH_RECOVER);
                end
                PH_WR_HIGH:
                begin
                    us_timer++;
                    if (us_timer >= dur(REG_W1_HIGH))
                        go(PH_RECOVER);
                end
                PH_RD_LOW:
                begin
                    r.drive_low = 1'b1;
                    us_timer++;
                    if (us_timer >= dur(REG_RD_LOW))
                        go(PH_RD_DELAY);
                end
                PH_RD_DELAY:
                begin
                    us_timer++;
                    if (us_timer >= dur(REG_RD_DELAY))
                        go(PH_RD_TAIL);
                end
                PH_RD_TAIL:
                begin
                    if (us_timer == 0)
                    begin
                        if (op == OP_RBYTE)
                            shift_byte = {line, shift_byte[7:1]};
                        else
                            shift_byte = {7'b0, line};
                    end
                    us_timer++;
                    if (us_timer >= dur(REG_RD_TAIL))
                        go(PH_RECOVER);
                end
                default:
                    go(PH_IDLE);
            endcase
        endfunction

        function void note_tick(logic [2:0] cmd, logic [7:0] tx, logic line);
            result_t r;
            logic    is_cmd;
            r      = '0;
            is_cmd = (cmd >= CMD_RESET) && (cmd <= CMD_RBIT);
            if (phase == PH_IDLE)
            begin
                if (is_cmd)
                begin
                    bit_index    = 0;
                    window_timer = 0;
                    if (cmd == CMD_RESET)
                    begin
                        op            = OP_RESET;
                        presence_flag = 1'b0;
                        crc           = 8'h00;
                        go(PH_RST_LOW);
                    end
                    else if (cmd == CMD_WRITE)
                    begin
                        op         = OP_WRITE;
                        shift_byte = tx;
                        go(PH_WR_LOW);
                    end
                    else
                    begin
                        op         = (cmd == CMD_RBYTE) ? OP_RBYTE : OP_RBIT;
                        shift_byte = 8'h00;
                        go(PH_RD_LOW);
                    end
                end
            end
            else if (is_cmd)
                r.rejected = 1'b1;
            if (phase != PH_IDLE)
                advance(line, r);
            r.busy_res = (phase != PH_IDLE);
            r.presence = presence_flag;
            r.crc_zero = (crc == 8'h00);
            owed.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got,
                         want);
        endtask

        task check_result(result_t got);
            result_t want;
            if (owed.size() == 0)
            begin
                report_mismatch("result with none pending", got, 0);
                return;
            end
            want = owed.pop_front();
            if (got.drive_low !== want.drive_low)
                report_mismatch("drive_low", got.drive_low, want.drive_low);
            if (got.busy_res !== want.busy_res)
                report_mismatch("busy_res", got.busy_res, want.busy_res);
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", got.done_res, want.done_res);
            if (got.presence !== want.presence)
                report_mismatch("presence", got.presence, want.presence);
            if (got.rx_data !== want.rx_data)
                report_mismatch("rx_data", got.rx_data, want.rx_data);
            if (got.crc_zero !== want.crc_zero)
                report_mismatch("crc_zero", got.crc_zero, want.crc_zero);
            if (got.rejected !== want.rejected)
                report_mismatch("rejected", got.rejected, want.rejected);
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [2:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    owm_in_if  in_ch();
    owm_out_if out_ch();

    bus_cycle_board board;
    result_t        seen_result;
    int             cycle_count = 0;
    logic           hold_req;
    bus_mode_t      line_mode;
    logic [7:0]     device_byte;
    int             run_left;
    logic           run_level;

    onewire_bus_master u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                board.note_tick(in_ch.cmd, in_ch.tx_byte, in_ch.line_level);
            if (out_ch.valid && out_ch.ready)
            begin
                seen_result = {out_ch.drive_low, out_ch.busy_res, out_ch.done_res,
                               out_ch.presence, out_ch.rx_data, out_ch.crc_zero,
                               out_ch.rejected};
                board.check_result(seen_result);
            end
        end
    end

    // receiver: changing stall patterns, plus one long hold-off on request
    initial
    begin : receiver
        int   stall_mode;
        int   mode_left;
        int   hold_left;
        int   beat;
        logic rdy;
        out_ch.ready = 1'b0;
        stall_mode   = 0;
        mode_left    = 0;
        hold_left    = 0;
        beat         = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                rdy       = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 150);
                end
                mode_left--;
                beat++;
                case (stall_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = (beat % 3 == 0);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    // line level seen by the master during the next microsecond
    function automatic logic bus_level();
        case (line_mode)
            BUS_HIGH:
                return 1'b1;
            BUS_STUCK_LOW:
                return 1'b0;
            BUS_LATCH_LOW:
                return (board.phase == PH_RST_WAIT_HIGH);
            BUS_DEVICE:
            begin
                case (board.phase)
                    PH_RST_LOW, PH_WR_LOW, PH_RD_LOW:
                        return 1'b0;
                    PH_RST_WINDOW:
                        return ($urandom_range(0, 2) == 0);
                    PH_RST_FREE:
                        return ($urandom_range(0, 2) == 0);
                    PH_RD_TAIL:
                        return device_byte[board.bit_index % 8];
                    default:
                        return 1'b1;
                endcase
            end
            default:
            begin
                if (run_left == 0)
                begin
                    run_level = $urandom_range(0, 1);
                    run_left  = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 6);
                end
                run_left--;
                return run_level;
            end
        endcase
    endfunction

    task automatic choose_bus();
        case ($urandom_range(0, 10))
            0, 1, 2, 3, 4: line_mode = BUS_DEVICE;
            5, 6, 7:       line_mode = BUS_NOISE;
            8:             line_mode = BUS_STUCK_LOW;
            9:             line_mode = BUS_LATCH_LOW;
            default:       line_mode = BUS_HIGH;
        endcase
        // reading back the running crc drives it to zero
        device_byte = ($urandom_range(0, 3) == 0) ? board.crc : 8'($urandom);
    endtask

    task automatic send_item(input logic [2:0] code, input logic [7:0] data,
                             input logic level);
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= code;
        in_ch.tx_byte    <= data;
        in_ch.line_level <= level;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.owed.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic finish_command();
        while (board.phase != PH_IDLE)
            send_item(CMD_TICK, 8'($urandom), bus_level());
        drain();
    endtask

    task automatic load_timing(input logic [CFG_W-1:0] vals [REG_COUNT]);
        for (int i = 0; i < REG_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_idx_t'(i);
            cfg_data  <= vals[i];
            board.timing[i] = vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // one command run to completion; poke sends every command while busy
    task automatic run_command(input logic [2:0] code, input logic [7:0] data,
                               input logic poke);
        int k;
        send_item(code, data, bus_level());
        k = 0;
        while (board.phase != PH_IDLE)
        begin
            k++;
            if (poke && k <= 4)
                send_item(3'(CMD_RESET + k - 1), 8'($urandom), bus_level());
            else
                send_item(CMD_TICK, 8'($urandom), bus_level());
        end
    endtask

    task automatic run_directed_set();
        line_mode   = BUS_DEVICE;
        device_byte = 8'h5A;
        run_command(CMD_RESET, 8'h00, 1'b1);
        run_command(CMD_WRITE, 8'hA5, 1'b1);
        run_command(CMD_WRITE, 8'hFF, 1'b0);
        run_command(CMD_WRITE, 8'h00, 1'b0);
        run_command(CMD_RBYTE, 8'hFF, 1'b1);
        device_byte = board.crc;
        run_command(CMD_RBYTE, 8'h00, 1'b0);
        device_byte = 8'h01;
        run_command(CMD_RBIT, 8'h00, 1'b1);
        line_mode = BUS_STUCK_LOW;
        run_command(CMD_RESET, 8'h00, 1'b0);
        line_mode = BUS_HIGH;
        run_command(CMD_RESET, 8'h00, 1'b0);
        line_mode = BUS_LATCH_LOW;
        run_command(CMD_RESET, 8'h00, 1'b0);
        line_mode = BUS_NOISE;
        run_command(CMD_RBIT, 8'h00, 1'b0);
    endtask

    task automatic run_random(input int count);
        int         burst_left;
        int         gap;
        int         pick;
        logic [2:0] code;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 3)
                hold_req = 1'b1;
            if (i == count / 2)
                drain();
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if ((board.phase == PH_IDLE && pick < 35) || pick < 3)
                code = 3'($urandom_range(CMD_RESET, CMD_RBIT));
            else if (pick < 40)
                code = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
            else
                code = CMD_TICK;
            if (board.phase == PH_IDLE && code >= CMD_RESET && code <= CMD_RBIT)
                choose_bus();
            send_item(code, 8'($urandom), bus_level());
        end
    endtask

    initial
    begin : stimulus
        logic [CFG_W-1:0] vals [REG_COUNT];
        board            = new();
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_RESET_LOW;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_TICK;
        in_ch.tx_byte    = 8'h00;
        in_ch.line_level = 1'b1;
        hold_req         = 1'b0;
        line_mode        = BUS_HIGH;
        device_byte      = 8'h00;
        run_left         = 0;
        run_level        = 1'b1;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default timings
        send_item(CMD_TICK, 8'h00, 1'b0);
        for (int u = CMD_UNUSED_FIRST; u <= CMD_UNUSED_LAST; u++)
            send_item(3'(u), 8'($urandom), bus_level());
        line_mode   = BUS_DEVICE;
        device_byte = 8'h01;
        run_command(CMD_RBIT, 8'h00, 1'b1);
        drain();

        // all timing registers zero, so every configured phase lasts one microsecond
        for (int i = 0; i < REG_COUNT; i++)
            vals[i] = '0;
        load_timing(vals);
        run_directed_set();
        run_random(250);
        finish_command();

        repeat (4)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                vals[i] = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(10, 40))
                                                      : CFG_W'($urandom_range(0, 6));
            load_timing(vals);
            run_random(280);
            finish_command();
        end

        repeat (8) @(negedge clk);
        if (board.owed.size() != 0)
            board.report_mismatch("results never returned", board.owed.size(), 0);
        if (board.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/owm_pkg.sv
hw/rtl/owm_if.sv
hw/rtl/owm_cfg_regs.sv
hw/rtl/owm_engine.sv
hw/rtl/owm_out_stage.sv
hw/rtl/onewire_bus_master.sv
tb/tb_onewire_bus_master.sv
